// ----- src/sfr_pkg.sv -----
// Package for the stream find-and-replace block: widths, register indexes,
// the configuration bundle and the burst control bundle.
// No dependencies.
`default_nettype none

package sfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int TEXT_BYTES = 16;
	localparam int TEXT_W     = TEXT_BYTES * BYTE_W;

	localparam logic [BYTE_W-1:0] NEWLINE = 8'h0A;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUBST_LEN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUBST_LO    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUBST_HI    = 3'd5;

	typedef struct packed {
		logic [LEN_W-1:0]  pattern_len;
		logic [TEXT_W-1:0] pattern;
		logic [LEN_W-1:0]  subst_len;
		logic [TEXT_W-1:0] subst;
	} cfg_t;

	// burst handed from the window logic to the output stage
	typedef struct packed {
		logic valid;
		logic nodata;
	} burst_ctl_t;

endpackage

`default_nettype wire

// ----- src/sfr_cfg.sv -----
// Configuration register file of the find-and-replace block.
// Depends on sfr_pkg.
`default_nettype none

module sfr_cfg (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [sfr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [sfr_pkg::CFG_DATA_W-1:0]         cfg_data,
	output sfr_pkg::cfg_t                          cfg
);

	logic [sfr_pkg::LEN_W-1:0]      pattern_len_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] pattern_lo_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] pattern_hi_q;
	logic [sfr_pkg::LEN_W-1:0]      subst_len_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] subst_lo_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] subst_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q <= sfr_pkg::LEN_W'(1);
			pattern_lo_q  <= '0;
			pattern_hi_q  <= '0;
			subst_len_q   <= sfr_pkg::LEN_W'(1);
			subst_lo_q    <= '0;
			subst_hi_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfr_pkg::REG_PATTERN_LEN: pattern_len_q <= cfg_data[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_PATTERN_LO:  pattern_lo_q  <= cfg_data;
				sfr_pkg::REG_PATTERN_HI:  pattern_hi_q  <= cfg_data;
				sfr_pkg::REG_SUBST_LEN:   subst_len_q   <= cfg_data[sfr_pkg::LEN_W-1:0];
				sfr_pkg::REG_SUBST_LO:    subst_lo_q    <= cfg_data;
				sfr_pkg::REG_SUBST_HI:    subst_hi_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.pattern_len = pattern_len_q;
	assign cfg.pattern     = {pattern_hi_q, pattern_lo_q};
	assign cfg.subst_len   = subst_len_q;
	assign cfg.subst       = {subst_hi_q, subst_lo_q};

endmodule

`default_nettype wire

// ----- src/sfr_window.sv -----
// Input register, window of undecided bytes and match/decision logic.
// Produces at most one burst descriptor per item. Depends on sfr_pkg.
`default_nettype none

module sfr_window #(
	parameter int WIN_DEPTH = 16,
	parameter int CW        = 5
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  sfr_pkg::cfg_t                  cfg,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [sfr_pkg::BYTE_W-1:0]     in_byte,
	input  wire                            in_eoi,
	output sfr_pkg::burst_ctl_t            burst,
	output logic [sfr_pkg::BYTE_W-1:0]     burst_bytes [WIN_DEPTH],
	output logic [CW-1:0]                  burst_cnt,
	input  wire                            burst_ready
);

	localparam int IW = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

	logic                        valid_s1;
	logic [sfr_pkg::BYTE_W-1:0]  byte_s1;
	logic                        eoi_s1;

	logic [sfr_pkg::BYTE_W-1:0]  win_q [WIN_DEPTH];
	logic [CW-1:0]               cnt_q;

	logic [CW-1:0]               plen;
	logic [CW-1:0]               slen;
	logic [sfr_pkg::BYTE_W-1:0]  win_a [WIN_DEPTH];
	logic [sfr_pkg::BYTE_W-1:0]  win_n [WIN_DEPTH];
	logic [CW-1:0]               cnt_a;
	logic [CW-1:0]               cnt_n;
	logic [CW-1:0]               shift;
	logic                        is_nl;
	logic                        full;
	logic                        match;
	logic                        adv;
	logic [CW:0]                 j;

	// lengths clamped to 1..WIN_DEPTH (pattern) and 0..WIN_DEPTH (replacement)
	always_comb begin
		if (cfg.pattern_len == '0)
			plen = CW'(1);
		else if (cfg.pattern_len > sfr_pkg::LEN_W'(WIN_DEPTH))
			plen = CW'(WIN_DEPTH);
		else
			plen = CW'(cfg.pattern_len);
		if (cfg.subst_len > sfr_pkg::LEN_W'(WIN_DEPTH))
			slen = CW'(WIN_DEPTH);
		else
			slen = CW'(cfg.subst_len);
	end

	assign is_nl = (byte_s1 == sfr_pkg::NEWLINE);
	assign cnt_a = cnt_q + CW'(1);
	assign full  = (cnt_a >= plen);

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_a[i] = ((CW+1)'(i) == {1'b0, cnt_q}) ? byte_s1 : win_q[i];
			if (((CW+1)'(i) < {1'b0, plen}) && (win_a[i] != cfg.pattern[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]))
				match = 1'b0;
		end
	end

	assign shift = match ? plen : CW'(1);

	always_comb begin
		j = '0;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			j = (CW+1)'(i) + {1'b0, shift};
			if (j < (CW+1)'(WIN_DEPTH))
				win_n[i] = win_a[j[IW-1:0]];
			else
				win_n[i] = '0;
		end
	end

	// burst descriptor
	always_comb begin
		burst.valid  = 1'b0;
		burst.nodata = 1'b0;
		burst_cnt    = CW'(1);
		cnt_n        = cnt_a;
		for (int i = 0; i < WIN_DEPTH; i++)
			burst_bytes[i] = win_a[i];
		if (eoi_s1) begin
			burst.valid = valid_s1;
			cnt_n       = '0;
			if (cnt_q == '0) begin
				burst.nodata   = 1'b1;
				burst_bytes[0] = '0;
			end else begin
				burst_cnt = cnt_q;
			end
		end else if (is_nl) begin
			burst.valid = valid_s1;
			cnt_n       = '0;
			burst_cnt   = cnt_a;
			for (int i = 0; i < WIN_DEPTH; i++)
				if ((CW+1)'(i) >= {1'b0, cnt_q})
					burst_bytes[i] = sfr_pkg::NEWLINE;
		end else if (full) begin
			cnt_n = cnt_a - shift;
			if (match) begin
				burst.valid = valid_s1 && (slen != '0);
				burst_cnt   = slen;
				for (int i = 0; i < WIN_DEPTH; i++)
					burst_bytes[i] = cfg.subst[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
			end else begin
				burst.valid = valid_s1;
			end
		end
	end

	assign adv      = valid_s1 && (!burst.valid || burst_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eoi_s1  <= in_eoi;
		end
		if (adv && !eoi_s1 && !is_nl) begin
			for (int i = 0; i < WIN_DEPTH; i++)
				win_q[i] <= full ? win_n[i] : win_a[i];
		end
	end

	a_win_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(WIN_DEPTH))
		else $error("window holds a full set of bytes after a step");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (eoi_s1 || is_nl) |=> cnt_q == '0)
		else $error("window not empty after flush");

endmodule

`default_nettype wire

// ----- src/sfr_emit.sv -----
// Output stage: holds one burst and sends its bytes one item per cycle while
// out_tready is high. Depends on sfr_pkg.
`default_nettype none

module sfr_emit #(
	parameter int WIN_DEPTH = 16,
	parameter int CW        = 5
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  sfr_pkg::burst_ctl_t            burst,
	input  wire  [sfr_pkg::BYTE_W-1:0]     burst_bytes [WIN_DEPTH],
	input  wire  [CW-1:0]                  burst_cnt,
	output logic                           burst_ready,
	output logic                           out_tvalid,
	input  wire                            out_tready,
	output logic [sfr_pkg::BYTE_W-1:0]     out_byte,
	output logic                           out_flag,
	output logic                           out_last
);

	localparam int IW = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

	logic                        busy_q;
	logic                        nodata_q;
	logic [IW-1:0]               idx_q;
	logic [IW-1:0]               last_q;
	logic [sfr_pkg::BYTE_W-1:0]  bytes_q [WIN_DEPTH];
	logic                        at_last;
	logic                        load;

	assign at_last     = (idx_q == last_q);
	assign burst_ready = !busy_q || (at_last && out_tready);
	assign load        = burst.valid && burst_ready;

	assign out_tvalid = busy_q;
	assign out_byte   = bytes_q[idx_q];
	assign out_flag   = !nodata_q;
	assign out_last   = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && out_tready) begin
			if (at_last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= burst_bytes;
			nodata_q <= burst.nodata;
			last_q   <= IW'(burst_cnt - CW'(1));
		end
	end

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && out_tready && !at_last |=> busy_q && idx_q == IW'($past(idx_q) + IW'(1)))
		else $error("burst index did not advance");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !out_tready |=> busy_q && $stable(idx_q))
		else $error("burst moved while stalled");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == '0)
		else $error("burst load failed");

endmodule

`default_nettype wire

// ----- src/stream_find_and_replace.sv -----
// Stream find-and-replace: top level with config registers, window logic
// and output stage. Depends on sfr_pkg, sfr_cfg, sfr_window, sfr_emit.
//
// Text bytes enter on the s_ side one item per cycle while s_tready is high;
// each byte is held in the input register while the window is compared with
// the pattern, and its results go to the output register. Plain text, where
// each item causes zero or one result, flows at one byte per clock while
// m_tready is high. An item that causes N results (a replacement of N bytes,
// or a flush at newline or at end of input) holds the output stage while its
// N results go out, one result per cycle while m_tready is high. Items that
// cause no result keep flowing meanwhile, but the next item that causes
// results waits in the input register and holds off further input until the
// output stage is on its last result. Matches never span a newline.
// Configuration registers are written through cfg_we/cfg_index/cfg_data by
// the user only while the stream is idle; the block does not enforce this.
`default_nettype none

module stream_find_and_replace #(
	parameter int MAX_LEN = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire  [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [sfr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,   // [7:0] data_byte
	input  wire                               s_tlast,   // end_of_input
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [7:0]                        m_tdata,   // [7:0] out_byte
	output logic                              m_tuser,   // [0] out_valid
	output logic                              m_tlast    // run_last
);

	localparam int WIN_DEPTH = (MAX_LEN < sfr_pkg::TEXT_BYTES) ? MAX_LEN : sfr_pkg::TEXT_BYTES;
	localparam int CW        = $clog2(WIN_DEPTH + 1);

	sfr_pkg::cfg_t               cfg;
	sfr_pkg::burst_ctl_t         burst;
	logic [sfr_pkg::BYTE_W-1:0]  burst_bytes [WIN_DEPTH];
	logic [CW-1:0]               burst_cnt;
	logic                        burst_ready;

	sfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sfr_window #(
		.WIN_DEPTH (WIN_DEPTH),
		.CW        (CW)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_byte     (s_tdata),
		.in_eoi      (s_tlast),
		.burst       (burst),
		.burst_bytes (burst_bytes),
		.burst_cnt   (burst_cnt),
		.burst_ready (burst_ready)
	);

	sfr_emit #(
		.WIN_DEPTH (WIN_DEPTH),
		.CW        (CW)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst),
		.burst_bytes (burst_bytes),
		.burst_cnt   (burst_cnt),
		.burst_ready (burst_ready),
		.out_tvalid  (m_tvalid),
		.out_tready  (m_tready),
		.out_byte    (m_tdata),
		.out_flag    (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

`default_nettype wire
